// ===== design/hsvrgb_pkg.sv =====
// hsvrgb_pkg: constants and sextant codes for the fixed-point hsv to rgb converter
// no dependencies; used by hsv_to_rgb_fixed_top
`default_nettype none

package hsvrgb_pkg;

  localparam int unsigned CW = 16;  // channel width

  // divisor for hue * 65536 -> sextant and fraction (about 65536 / 6)
  localparam logic [13:0] SEXT_DIV = 14'd10923;
  // floor(2^32 / 10923); the estimate is exact or one short
  localparam logic [18:0] SEXT_RECIP = 19'd393204;
  localparam logic [31:0] ROUND_BIAS = 32'h0000_7FFF;
  localparam logic [16:0] UNITY = 17'h1_0000;

  typedef logic [2:0] sextant_t;

  localparam sextant_t SEXT_RED_YEL = 3'd0;
  localparam sextant_t SEXT_YEL_GRN = 3'd1;
  localparam sextant_t SEXT_GRN_CYN = 3'd2;
  localparam sextant_t SEXT_CYN_BLU = 3'd3;
  localparam sextant_t SEXT_BLU_MAG = 3'd4;
  localparam sextant_t SEXT_MAG_RED = 3'd5;

endpackage

`default_nettype wire

// ===== design/hsv_to_rgb_fixed_top.sv =====
// hsv_to_rgb_fixed_top: six-stage pipelined fixed-point hsv to rgb converter
// depends on hsvrgb_pkg for constants and sextant codes
// done is the start strobe carried through the stage valid bits v1 to v6
// throughput: one beat per clock; busy is held low and the pipe never stalls
// the sextant divide is a reciprocal multiply, a back-multiply and one correction step
// reset (rst, synchronous, active high) clears the stage valid bits; data is not reset
`default_nettype none

module hsv_to_rgb_fixed_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] hue,
  input  wire logic [15:0] saturation,
  input  wire logic [15:0] brightness,
  output logic             done,
  output logic [15:0]      red,
  output logic [15:0]      green,
  output logic [15:0]      blue
);

  // stage valid bits
  logic v1, v2, v3, v4, v5, v6;

  // stage 1: quotient estimate and p
  logic [15:0] h1, s1, b1, p1;
  logic [18:0] e1;
  logic [34:0] est_prod;
  logic [32:0] p_prod;

  // stage 2: back-multiply
  logic [15:0] h2, s2, b2, p2;
  logic [18:0] e2;
  logic [31:0] ex2;
  logic [32:0] ex_prod;

  // stage 3: corrected sextant and fraction
  logic [15:0] s3, b3, p3, frac3;
  hsvrgb_pkg::sextant_t sext3;
  logic [31:0] rem;
  logic [18:0] quot;

  // stage 4: scaled saturation terms
  logic [15:0] b4, p4, sf4, sg4;
  hsvrgb_pkg::sextant_t sext4;
  logic [32:0] sf_prod, sg_prod;

  // stage 5: q and t
  logic [15:0] b5, p5, q5, t5;
  hsvrgb_pkg::sextant_t sext5;
  logic [32:0] q_prod, t_prod;

  // stage 6 routing
  logic [15:0] red_next, green_next, blue_next;

  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign est_prod = 35'(hue) * 35'(hsvrgb_pkg::SEXT_RECIP);
  assign p_prod   = 33'(brightness) * 33'(hsvrgb_pkg::UNITY - {1'b0, saturation});

  assign ex_prod = 33'(e1) * 33'(hsvrgb_pkg::SEXT_DIV);

  // remainder stays below twice the divisor, so one step fixes the estimate
  assign rem  = {h2, 16'h0000} - ex2;
  assign quot = (rem >= 32'(hsvrgb_pkg::SEXT_DIV)) ? (e2 + 19'd1) : e2;

  assign sf_prod = 33'(s3) * 33'(frac3) + 33'(hsvrgb_pkg::ROUND_BIAS);
  assign sg_prod = 33'(s3) * 33'(hsvrgb_pkg::UNITY - {1'b0, frac3})
                 + 33'(hsvrgb_pkg::ROUND_BIAS);

  assign q_prod = 33'(b4) * 33'(hsvrgb_pkg::UNITY - {1'b0, sf4}) + 33'(hsvrgb_pkg::ROUND_BIAS);
  assign t_prod = 33'(b4) * 33'(hsvrgb_pkg::UNITY - {1'b0, sg4}) + 33'(hsvrgb_pkg::ROUND_BIAS);

  always_comb begin
    case (sext5)
      hsvrgb_pkg::SEXT_YEL_GRN: begin
        red_next = q5; green_next = b5; blue_next = p5;
      end
      hsvrgb_pkg::SEXT_GRN_CYN: begin
        red_next = p5; green_next = b5; blue_next = t5;
      end
      hsvrgb_pkg::SEXT_CYN_BLU: begin
        red_next = p5; green_next = q5; blue_next = b5;
      end
      hsvrgb_pkg::SEXT_BLU_MAG: begin
        red_next = t5; green_next = p5; blue_next = b5;
      end
      hsvrgb_pkg::SEXT_MAG_RED: begin
        red_next = b5; green_next = p5; blue_next = q5;
      end
      default: begin
        red_next = b5; green_next = t5; blue_next = p5;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    h1 <= hue;
    s1 <= saturation;
    b1 <= brightness;
    e1 <= est_prod[34:16];
    p1 <= p_prod[31:16];

    h2  <= h1;
    s2  <= s1;
    b2  <= b1;
    p2  <= p1;
    e2  <= e1;
    ex2 <= ex_prod[31:0];

    s3    <= s2;
    b3    <= b2;
    p3    <= p2;
    sext3 <= quot[18:16];
    frac3 <= quot[15:0];

    b4    <= b3;
    p4    <= p3;
    sext4 <= sext3;
    sf4   <= sf_prod[31:16];
    sg4   <= sg_prod[31:16];

    b5    <= b4;
    p5    <= p4;
    sext5 <= sext4;
    q5    <= q_prod[31:16];
    t5    <= t_prod[31:16];

    red   <= red_next;
    green <= green_next;
    blue  <= blue_next;
  end

  assign done = v6;

  // every accepted beat comes out as a done strobe, and nothing else does
  a_latency : assert property (@(posedge clk) disable iff (rst)
    accept |-> ##6 done)
    else $error("accepted beat did not appear after six cycles");

  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    !accept |-> ##6 !done)
    else $error("result strobe without an accepted beat");

  // corrected quotient always lands in sextants zero to five
  a_sextant_range : assert property (@(posedge clk) disable iff (rst)
    v4 |-> (sext4 <= hsvrgb_pkg::SEXT_MAG_RED))
    else $error("sextant out of range after divide correction");

  // one channel carries the value and none exceeds it
  a_channel_bound : assert property (@(posedge clk) disable iff (rst)
    done |-> ((red == $past(brightness, 6) || green == $past(brightness, 6)
               || blue == $past(brightness, 6))
              && red <= $past(brightness, 6) && green <= $past(brightness, 6)
              && blue <= $past(brightness, 6)))
    else $error("channel routing does not match the value component");

endmodule

`default_nettype wire
